[design/ddays_pkg.sv]
// Shared types, widths and constants for the date difference block.
`default_nettype none

package ddays_pkg;

    // Port field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DIFF_W  = 23;

    localparam int MAX_YEAR_DEF = 9999;

    // Internal widths: day numbers stay below 2^24 for any 14-bit year
    localparam int DN_W       = 24;
    localparam int DIFF_EXT_W = DN_W + 1;
    localparam int PROD_Y_W   = 23;
    localparam int PROD_Q_W   = 27;
    localparam int DIV100_SH  = 19;
    localparam int Q100_W     = PROD_Q_W - DIV100_SH;

    localparam int DAYS_PER_YEAR = 365;
    // floor(c / 100) == (c * 5243) >> 19 for every c below 2^14
    localparam int DIV100_MUL    = 5243;

    localparam logic signed [DIFF_EXT_W-1:0] DIFF_MAX = DIFF_EXT_W'((1 << (DIFF_W - 1)) - 1);
    localparam logic signed [DIFF_EXT_W-1:0] DIFF_MIN = -DIFF_EXT_W'(1 << (DIFF_W - 1));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_A_MUL,
        ST_A_SUM,
        ST_A_FIN,
        ST_B_MUL,
        ST_B_SUM,
        ST_B_FIN,
        ST_DIFF
    } ddays_state_t;

    typedef struct packed {
        logic load;       // capture input item
        logic sel_b;      // datapath works on the second date
        logic mul_en;     // stage 1: clamp and products
        logic sum_en;     // stage 2: year part and leap flag
        logic fin_en;     // stage 3: month and day, store day number
        logic out_load;   // write difference into output register
    } ddays_cmd_t;

    typedef struct packed {
        logic out_free;   // output register empty or being taken
    } ddays_stat_t;

    // Days before the first of a month in a common year; month already clamped to 1..12
    function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[design/date_difference_in_days.sv]
// Top level: signed day count between two Gregorian dates.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | first/second year, month, day
//  m_      | out       | m_valid / m_ready | day_difference (23-bit signed)
//
// One item occupies the block through the accept cycle, three steps through the shared
// day-number unit for each date (clamp/multiply, year sum, month/day add) and one step
// for the difference; the next item is accepted only after that step has written the result.
// A finished result sits in the output register; the next item is accepted
// meanwhile and stalls only in its last cycle if that result is still not taken.
// Reset is synchronous, active low, and clears the controller and m_valid.
`default_nettype none

module date_difference_in_days
    import ddays_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [YEAR_W-1:0]     s_first_year,
    input  wire logic [MONTH_W-1:0]    s_first_month,
    input  wire logic [DAY_W-1:0]      s_first_day,
    input  wire logic [YEAR_W-1:0]     s_second_year,
    input  wire logic [MONTH_W-1:0]    s_second_month,
    input  wire logic [DAY_W-1:0]      s_second_day,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [DIFF_W-1:0]   m_day_difference
);

    ddays_cmd_t  cmd;
    ddays_stat_t stat;

    ddays_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ddays_dp #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_first_year     (s_first_year),
        .s_first_month    (s_first_month),
        .s_first_day      (s_first_day),
        .s_second_year    (s_second_year),
        .s_second_month   (s_second_month),
        .s_second_day     (s_second_day),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_day_difference (m_day_difference)
    );

endmodule

`default_nettype wire

[design/ddays_ctrl.sv]
// Controller: sequences the two day-number passes and the output write.
`default_nettype none

module ddays_ctrl
    import ddays_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire ddays_stat_t stat,
    output ddays_cmd_t       cmd
);

    ddays_state_t state_reg;
    ddays_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_A_MUL;
                end
            end
            ST_A_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_A_SUM;
            end
            ST_A_SUM: begin
                cmd.sum_en = 1'b1;
                state_next = ST_A_FIN;
            end
            ST_A_FIN: begin
                cmd.fin_en = 1'b1;
                state_next = ST_B_MUL;
            end
            ST_B_MUL: begin
                cmd.sel_b  = 1'b1;
                cmd.mul_en = 1'b1;
                state_next = ST_B_SUM;
            end
            ST_B_SUM: begin
                cmd.sel_b  = 1'b1;
                cmd.sum_en = 1'b1;
                state_next = ST_B_FIN;
            end
            ST_B_FIN: begin
                cmd.sel_b  = 1'b1;
                cmd.fin_en = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                // hold until the previous result has been taken
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/ddays_dp.sv]
// Datapath: shared day-number unit, difference with saturation, output register.
`default_nettype none

module ddays_dp
    import ddays_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire ddays_cmd_t                cmd,
    output ddays_stat_t                    stat,
    input  wire logic [YEAR_W-1:0]         s_first_year,
    input  wire logic [MONTH_W-1:0]        s_first_month,
    input  wire logic [DAY_W-1:0]          s_first_day,
    input  wire logic [YEAR_W-1:0]         s_second_year,
    input  wire logic [MONTH_W-1:0]        s_second_month,
    input  wire logic [DAY_W-1:0]          s_second_day,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [DIFF_W-1:0]       m_day_difference
);

    localparam int YEAR_LIMIT = (1 << YEAR_W) - 1;
    localparam logic [YEAR_W-1:0] YEAR_CAP =
        YEAR_W'((MAX_YEAR > YEAR_LIMIT) ? YEAR_LIMIT : MAX_YEAR);

    // captured item
    logic [YEAR_W-1:0]  a_year_reg, b_year_reg;
    logic [MONTH_W-1:0] a_month_reg, b_month_reg;
    logic [DAY_W-1:0]   a_day_reg, b_day_reg;

    // stage 1
    logic [YEAR_W-1:0]   yr_sel, yr_lo, yr_cl, c_s1;
    logic [MONTH_W-1:0]  mo_sel, mo_cl;
    logic [YEAR_W-1:0]   c_reg;
    logic [MONTH_W-1:0]  m_reg;
    logic [DAY_W-1:0]    d_reg;
    logic [PROD_Y_W-1:0] prod_y_reg, prod_y_next;
    logic [PROD_Q_W-1:0] prod_q_reg, prod_q_next;

    // stage 2
    logic [Q100_W-1:0] q100, q400;
    logic [YEAR_W-1:0] hundreds, rem100;
    logic              c_rem99, leap_next, leap_reg;
    logic [DN_W-1:0]   n1_reg, n1_next;

    // stage 3
    logic [DN_W-1:0] dn_next, dn_a_reg, dn_b_reg;

    // output
    logic signed [DIFF_EXT_W-1:0] diff;
    logic signed [DIFF_W-1:0]     diff_sat;
    logic                         m_valid_reg;
    logic signed [DIFF_W-1:0]     m_diff_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_year_reg  <= s_first_year;
            a_month_reg <= s_first_month;
            a_day_reg   <= s_first_day;
            b_year_reg  <= s_second_year;
            b_month_reg <= s_second_month;
            b_day_reg   <= s_second_day;
        end
    end

    // Stage 1: clamp year and month, c = year - 1, products for c*365 and c/100
    always_comb begin
        yr_sel = cmd.sel_b ? b_year_reg : a_year_reg;
        mo_sel = cmd.sel_b ? b_month_reg : a_month_reg;
        yr_lo  = (yr_sel == '0) ? YEAR_W'(1) : yr_sel;
        yr_cl  = (yr_lo > YEAR_CAP) ? YEAR_CAP : yr_lo;
        c_s1   = yr_cl - YEAR_W'(1);
        if (mo_sel == '0) begin
            mo_cl = MONTH_W'(1);
        end else if (mo_sel > MONTH_W'(12)) begin
            mo_cl = MONTH_W'(12);
        end else begin
            mo_cl = mo_sel;
        end
        prod_y_next = PROD_Y_W'(c_s1) * PROD_Y_W'(DAYS_PER_YEAR);
        prod_q_next = PROD_Q_W'(c_s1) * PROD_Q_W'(DIV100_MUL);
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            c_reg      <= c_s1;
            m_reg      <= mo_cl;
            d_reg      <= cmd.sel_b ? b_day_reg : a_day_reg;
            prod_y_reg <= prod_y_next;
            prod_q_reg <= prod_q_next;
        end
    end

    // Stage 2: whole-year days and leap flag
    // year % 4 == 0 <=> c % 4 == 3; year % 100 == 0 <=> c % 100 == 99
    always_comb begin
        q100     = prod_q_reg[PROD_Q_W-1:DIV100_SH];
        q400     = q100 >> 2;
        hundreds = YEAR_W'({q100, 6'b0}) + YEAR_W'({q100, 5'b0}) + YEAR_W'({q100, 2'b0});
        rem100   = c_reg - hundreds;
        c_rem99  = (rem100 == YEAR_W'(99));
        leap_next = ((c_reg[1:0] == 2'b11) && !c_rem99) || (c_rem99 && (q100[1:0] == 2'b11));
        n1_next  = DN_W'(prod_y_reg) + DN_W'(c_reg >> 2) - DN_W'(q100) + DN_W'(q400);
    end

    always_ff @(posedge aclk) begin
        if (cmd.sum_en) begin
            n1_reg   <= n1_next;
            leap_reg <= leap_next;
        end
    end

    // Stage 3: month offset, leap day, day of month
    assign dn_next = n1_reg + DN_W'(month_offset(m_reg))
                   + DN_W'(leap_reg && (m_reg > MONTH_W'(2))) + DN_W'(d_reg);

    always_ff @(posedge aclk) begin
        if (cmd.fin_en) begin
            if (cmd.sel_b) begin
                dn_b_reg <= dn_next;
            end else begin
                dn_a_reg <= dn_next;
            end
        end
    end

    // Difference and saturation to the output width
    always_comb begin
        diff = $signed({1'b0, dn_a_reg}) - $signed({1'b0, dn_b_reg});
        priority if (diff > DIFF_MAX) begin
            diff_sat = DIFF_W'(DIFF_MAX);
        end else if (diff < DIFF_MIN) begin
            diff_sat = DIFF_W'(DIFF_MIN);
        end else begin
            diff_sat = diff[DIFF_W-1:0];
        end
    end

    assign stat.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_diff_reg <= diff_sat;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_day_difference = m_diff_reg;

endmodule

`default_nettype wire

[design/ddays_chk.sv]
// Port-level checker for the date difference block, bound to the top level.
`default_nettype none

module ddays_chk (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [22:0] m_day_difference
);

    // items accepted whose result has not yet been taken
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    always_comb begin
        pending_next = pending_reg;
        if ((s_valid && s_ready) && !(m_valid && m_ready)) begin
            pending_next = pending_reg + 2'd1;
        end else if (!(s_valid && s_ready) && (m_valid && m_ready)) begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_day_difference))
        else $error("result dropped or changed while stalled");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 2'd0)
        else $error("result without an accepted item");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == 2'd2 |-> !s_ready)
        else $error("item accepted with two items outstanding");

endmodule

bind date_difference_in_days ddays_chk u_ddays_chk (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_day_difference (m_day_difference)
);

`default_nettype wire

[test/date_difference_in_days_tb.sv]
// Testbench for date_difference_in_days: directed date table plus random pairs vs a day-count model.
`timescale 1ns / 1ps

module date_difference_in_days_tb;
    import ddays_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int ITEMS_PER_PHASE = 260;
    localparam int DIRECTED_N   = 24;
    localparam int DRAIN_CYCLES = 16;

    localparam int MONTH_START [0:11] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    typedef struct packed {
        logic [YEAR_W-1:0]         first_year;
        logic [MONTH_W-1:0]        first_month;
        logic [DAY_W-1:0]          first_day;
        logic [YEAR_W-1:0]         second_year;
        logic [MONTH_W-1:0]        second_month;
        logic [DAY_W-1:0]          second_day;
        logic                      pinned;
        logic signed [DIFF_W-1:0]  diff;
    } date_row_t;

    // Rows with pinned set carry a result that follows directly from the calendar.
    date_row_t directed_rows [0:DIRECTED_N-1] = '{
        '{14'd2000, 4'd1, 5'd1, 14'd2000, 4'd1, 5'd1, 1'b1, 23'sd0},
        '{14'd1, 4'd1, 5'd1, 14'd1, 4'd1, 5'd1, 1'b1, 23'sd0},
        '{14'd9999, 4'd12, 5'd31, 14'd1, 4'd1, 5'd1, 1'b1, 23'sd3652058},
        '{14'd1, 4'd1, 5'd1, 14'd9999, 4'd12, 5'd31, 1'b1, -23'sd3652058},
        '{14'd0, 4'd6, 5'd15, 14'd1, 4'd6, 5'd15, 1'b1, 23'sd0},
        '{14'd16383, 4'd6, 5'd15, 14'd9999, 4'd6, 5'd15, 1'b1, 23'sd0},
        '{14'd2001, 4'd0, 5'd10, 14'd2001, 4'd1, 5'd10, 1'b1, 23'sd0},
        '{14'd2001, 4'd15, 5'd10, 14'd2001, 4'd12, 5'd10, 1'b1, 23'sd0},
        '{14'd2001, 4'd13, 5'd10, 14'd2001, 4'd12, 5'd10, 1'b1, 23'sd0},
        '{14'd2001, 4'd4, 5'd31, 14'd2001, 4'd5, 5'd1, 1'b1, 23'sd0},
        '{14'd2001, 4'd3, 5'd0, 14'd2001, 4'd2, 5'd28, 1'b1, 23'sd0},
        '{14'd2000, 4'd3, 5'd1, 14'd2000, 4'd2, 5'd28, 1'b1, 23'sd2},
        '{14'd1900, 4'd3, 5'd1, 14'd1900, 4'd2, 5'd28, 1'b1, 23'sd1},
        '{14'd2004, 4'd3, 5'd1, 14'd2004, 4'd2, 5'd28, 1'b1, 23'sd2},
        '{14'd2100, 4'd3, 5'd1, 14'd2100, 4'd2, 5'd28, 1'b1, 23'sd1},
        '{14'd2001, 4'd1, 5'd1, 14'd2000, 4'd1, 5'd1, 1'b1, 23'sd366},
        '{14'd2002, 4'd1, 5'd1, 14'd2001, 4'd1, 5'd1, 1'b1, 23'sd365},
        '{14'd16383, 4'd15, 5'd31, 14'd0, 4'd0, 5'd0, 1'b1, 23'sd3652059},
        '{14'd0, 4'd0, 5'd0, 14'd16383, 4'd15, 5'd31, 1'b1, -23'sd3652059},
        '{14'd2024, 4'd2, 5'd29, 14'd1970, 4'd1, 5'd1, 1'b0, 23'sd0},
        '{14'd1582, 4'd10, 5'd15, 14'd1600, 4'd3, 5'd1, 1'b0, 23'sd0},
        '{14'd2400, 4'd12, 5'd31, 14'd2400, 4'd1, 5'd1, 1'b0, 23'sd0},
        '{14'd10922, 4'd10, 5'd21, 14'd5461, 4'd5, 5'd10, 1'b0, 23'sd0},
        '{14'd5461, 4'd5, 5'd10, 14'd10922, 4'd10, 5'd21, 1'b0, 23'sd0}
    };

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [YEAR_W-1:0]         s_first_year = '0;
    logic [MONTH_W-1:0]        s_first_month = '0;
    logic [DAY_W-1:0]          s_first_day = '0;
    logic [YEAR_W-1:0]         s_second_year = '0;
    logic [MONTH_W-1:0]        s_second_month = '0;
    logic [DAY_W-1:0]          s_second_day = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [DIFF_W-1:0]  m_day_difference;

    // expectation that travels with the payload of a pinned row
    logic                      pin_valid = 1'b0;
    logic signed [DIFF_W-1:0]  pin_diff = '0;

    logic signed [DIFF_W-1:0]  pending_diffs [$];
    int                        error_count = 0;
    int                        cycle_count = 0;
    int                        src_idle_pct = 0;
    int                        sink_stall_pct = 0;
    int                        hold_req = 0;
    int                        hold_ack = 0;
    int                        hold_left = 0;

    date_difference_in_days uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_first_year     (s_first_year),
        .s_first_month    (s_first_month),
        .s_first_day      (s_first_day),
        .s_second_year    (s_second_year),
        .s_second_month   (s_second_month),
        .s_second_day     (s_second_day),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_day_difference (m_day_difference)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Days since the proleptic epoch, with out-of-range years and months clamped.
    function automatic longint gregorian_day_number(input logic [YEAR_W-1:0] yr,
                                                    input logic [MONTH_W-1:0] mo,
                                                    input logic [DAY_W-1:0] dy);
        longint y;
        longint m;
        longint c;
        longint n;
        y = longint'(yr);
        m = longint'(mo);
        if (y < 1) y = 1;
        if (y > MAX_YEAR_DEF) y = MAX_YEAR_DEF;
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        c = y - 1;
        n = c * 365 + c / 4 - c / 100 + c / 400 + MONTH_START[m - 1];
        if (m > 2 && (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0))) n++;
        return n + longint'(dy);
    endfunction

    function automatic logic signed [DIFF_W-1:0] days_between(input date_row_t r);
        longint d;
        longint hi;
        longint lo;
        hi = (longint'(1) << (DIFF_W - 1)) - 1;
        lo = -(longint'(1) << (DIFF_W - 1));
        d = gregorian_day_number(r.first_year, r.first_month, r.first_day)
            - gregorian_day_number(r.second_year, r.second_month, r.second_day);
        if (d > hi) d = hi;
        if (d < lo) d = lo;
        return DIFF_W'(d);
    endfunction

    function automatic logic [YEAR_W-1:0] random_year();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? '0 : '1;
            1: return YEAR_W'($urandom_range(16383, MAX_YEAR_DEF + 1));
            2: return YEAR_W'($urandom_range(1, 99) * 100);
            3: return YEAR_W'($urandom_range(1, 2499) * 4);
            default: return YEAR_W'($urandom_range(1, MAX_YEAR_DEF));
        endcase
    endfunction

    function automatic date_row_t random_date_pair();
        date_row_t r;
        r.first_year   = random_year();
        r.first_month  = ($urandom_range(7) == 0) ? MONTH_W'($urandom_range(15))
                                                  : MONTH_W'($urandom_range(1, 12));
        r.first_day    = DAY_W'($urandom_range(31));
        // close pairs keep small differences and year boundaries busy
        r.second_year  = ($urandom_range(9) < 4)
                         ? YEAR_W'(r.first_year + $urandom_range(4) - 2)
                         : random_year();
        r.second_month = ($urandom_range(7) == 0) ? MONTH_W'($urandom_range(15))
                                                  : MONTH_W'($urandom_range(1, 12));
        r.second_day   = DAY_W'($urandom_range(31));
        r.pinned       = 1'b0;
        r.diff         = '0;
        return r;
    endfunction

    task automatic offer_item(input date_row_t r);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_first_year   <= r.first_year;
        s_first_month  <= r.first_month;
        s_first_day    <= r.first_day;
        s_second_year  <= r.second_year;
        s_second_month <= r.second_month;
        s_second_day   <= r.second_day;
        pin_valid      <= r.pinned;
        pin_diff       <= r.diff;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_diffs.size() != 0) @(posedge aclk);
    endtask

    task automatic flag_mismatch(input string what, input logic signed [DIFF_W-1:0] want,
                                 input logic signed [DIFF_W-1:0] got);
        error_count++;
        if (error_count <= 10)
            $display("%s: expected %0d, got %0d (cycle %0d)", what, want, got, cycle_count);
    endtask

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_diffs.size() == 0)
                    flag_mismatch("unexpected item", '0, m_day_difference);
                else if (m_day_difference !== pending_diffs[0])
                    flag_mismatch("day_difference", pending_diffs.pop_front(), m_day_difference);
                else
                    void'(pending_diffs.pop_front());
            end
            if (s_valid && s_ready)
                pending_diffs.push_back(pin_valid ? pin_diff
                    : days_between('{s_first_year, s_first_month, s_first_day,
                                     s_second_year, s_second_month, s_second_day,
                                     1'b0, '0}));
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("date_difference_in_days_tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_N; i++)
            offer_item(directed_rows[i]);
        wait_results_drained();

        // idle mix per phase: none, sender gaps, receiver stalls, light on both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
                1: begin src_idle_pct = 48; sink_stall_pct <= 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct <= 48; end
                default: begin src_idle_pct = 6; sink_stall_pct <= 6; end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // long receiver hold-off while the sender keeps pushing
                if ((phase == 0 || phase == 3) && i == 60) hold_req <= hold_req + 1;
                offer_item(random_date_pair());
            end
            wait_results_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_diffs.size() != 0) begin
            error_count += pending_diffs.size();
            $display("%0d expected items never came out", pending_diffs.size());
        end
        if (error_count == 0) begin
            $display("date_difference_in_days_tb: clean");
        end else begin
            $display("date_difference_in_days_tb: errors");
        end
        $finish;
    end

endmodule

[filelist.f]
design/ddays_pkg.sv
design/ddays_ctrl.sv
design/ddays_dp.sv
design/date_difference_in_days.sv
design/ddays_chk.sv
test/date_difference_in_days_tb.sv
